// ===== sv/lbh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Letter bigram histogram package
// Shared types and constants for the letter bigram histogram unit.
// ----------------------------------------------------------------------------
package lbh_pkg;

    // Widths of the request and result fields.
    localparam int CODE_W   = 8;
    localparam int LETTER_W = 5;
    localparam int OUT_W    = 32;

    // Codes from here upwards are letters; upper case folds onto lower case
    // because both halves share the low five bits.
    localparam logic [CODE_W-1:0] LETTER_FIRST = 8'hC0;

    // Request commands.
    typedef enum logic {
        CMD_FEED  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Control states: clearing the table after reset, then normal running.
    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

endpackage : lbh_pkg
`default_nettype wire

// ===== sv/lbh_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module lbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : lbh_ram
`default_nettype wire

// ===== sv/letter_bigram_histogram_unit.sv =====
`default_nettype none
// A query request gives its result with done high after the second stage registers and
// the result registers. One request per cycle while busy is low; a counter update is a
// read-modify-write of the pair table RAM, with forwarding when the next request hits the
// same entry. Reset: all control state clears at once; a clearing pass then writes zero
// to all ALPHABET_SIZE*ALPHABET_SIZE table entries (1024 by default), one per cycle, and
// busy stays high until it ends. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// Letter bigram histogram unit
// Counts pairs of adjacent Cyrillic letters in a byte stream and answers
// queries for the count of one pair together with the total.
// ----------------------------------------------------------------------------
module letter_bigram_histogram_unit #(
    parameter int ALPHABET_SIZE = 32,
    parameter int COUNT_WIDTH   = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          command,
    input  wire logic [lbh_pkg::CODE_W-1:0]    char_code,
    input  wire logic [lbh_pkg::LETTER_W-1:0]  first_letter,
    input  wire logic [lbh_pkg::LETTER_W-1:0]  second_letter,
    output logic                               done,
    output logic [lbh_pkg::OUT_W-1:0]          pair_count,
    output logic [lbh_pkg::OUT_W-1:0]          total_pairs
);

    import lbh_pkg::*;

    localparam int DEPTH  = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [ADDR_W-1:0]      addr_t;

    // Saturating increment.
    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == '1) ? v : v + COUNT_WIDTH'(1);
        return r;
    endfunction

    // Table slot of a letter pair.
    function automatic addr_t slot_of(input logic [LETTER_W-1:0] hi,
                                      input logic [LETTER_W-1:0] lo);
        addr_t r;
        r = ADDR_W'(hi) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(lo);
        return r;
    endfunction

    state_t              state_reg, state_next;
    addr_t               clr_addr_reg, clr_addr_next;
    logic                clr_we;
    logic                accept;
    logic                is_query;
    logic [LETTER_W-1:0] code_idx;
    logic                is_letter;
    logic                count_pair;
    logic                query_in_range;
    addr_t               rd_addr;

    logic [LETTER_W-1:0] prev_letter_reg;
    logic                prev_valid_reg;
    count_t              total_reg;

    logic                s1_valid_reg;
    logic                s1_query_reg;
    logic                s1_inc_reg;
    logic                s1_in_range_reg;
    addr_t               s1_addr_reg;
    count_t              s1_total_reg;

    logic                fwd_hit_reg;
    count_t              fwd_data_reg;

    count_t              ram_rdata;
    count_t              cur_count;
    count_t              upd_count;
    logic                run_we;
    logic                ram_we;
    addr_t               ram_waddr;
    count_t              ram_wdata;

    logic                done_reg;
    logic [OUT_W-1:0]    pair_count_reg;
    logic [OUT_W-1:0]    total_pairs_reg;

    // Next state of the clearing sequencer.
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the clearing sequencer.
    always_comb
    begin
        unique case (state_reg)
            ST_CLEAR:
            begin
                busy   = 1'b1;
                clr_we = 1'b1;
            end
            ST_RUN:
            begin
                busy   = 1'b0;
                clr_we = 1'b0;
            end
            default:
            begin
                busy   = 1'b1;
                clr_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Request decode: fold the letter, check the alphabet and pick the slot.
    assign accept         = start && !busy;
    assign is_query       = (command == CMD_QUERY);
    assign code_idx       = char_code[LETTER_W-1:0];
    assign is_letter      = (char_code >= LETTER_FIRST) && (32'(code_idx) < ALPHABET_SIZE);
    assign count_pair     = !is_query && is_letter && prev_valid_reg;
    assign query_in_range = (32'(first_letter) < ALPHABET_SIZE)
                         && (32'(second_letter) < ALPHABET_SIZE);
    assign rd_addr        = is_query ? slot_of(first_letter, second_letter)
                                     : slot_of(prev_letter_reg, code_idx);

    // Previous letter and the total count move at the request itself.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_letter_reg <= '0;
            prev_valid_reg  <= 1'b0;
            total_reg       <= '0;
        end
        else if (accept && !is_query)
        begin
            prev_valid_reg <= is_letter;
            if (is_letter)
            begin
                prev_letter_reg <= code_idx;
            end
            if (count_pair)
            begin
                total_reg <= sat_inc(total_reg);
            end
        end
    end

    // Second stage control: one request in flight while the RAM reads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_hit_reg  <= accept && run_we && (s1_addr_reg == rd_addr);
        end
    end

    // Second stage payload and the forwarded count.
    always_ff @(posedge clk)
    begin
        s1_query_reg    <= is_query;
        s1_inc_reg      <= count_pair;
        s1_in_range_reg <= query_in_range;
        s1_addr_reg     <= rd_addr;
        s1_total_reg    <= total_reg;
        fwd_data_reg    <= upd_count;
    end

    // Read-modify-write of the pair counter, with the value being written
    // forwarded when the following request reads the same entry.
    assign cur_count = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign upd_count = sat_inc(cur_count);
    assign run_we    = s1_valid_reg && s1_inc_reg;
    assign ram_we    = clr_we || run_we;
    assign ram_waddr = clr_we ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_we ? '0 : upd_count;

    lbh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_pair_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg && s1_query_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_count_reg  <= s1_in_range_reg ? OUT_W'(cur_count) : '0;
        total_pairs_reg <= OUT_W'(s1_total_reg);
    end

    assign done        = done_reg;
    assign pair_count  = pair_count_reg;
    assign total_pairs = total_pairs_reg;

    // A query request always gives a result once it has passed the second stage and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_query) |-> ##2 done)
        else $error("query request without a result");

    // A feed request never gives a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_query) |-> ##2 !done)
        else $error("result after a feed request");

    // The clearing pass never shares the write port with a counter update.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s1_valid_reg)
        else $error("counter update during the clearing pass");

    // The total count never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (total_reg >= $past(total_reg)))
        else $error("total count decreased");

endmodule : letter_bigram_histogram_unit
`default_nettype wire
